### hw/rtl/lt_tile_box_address_walker_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tile box address walker
// Shared property forms, clocked on i_clk, for the walker's checker.
// ----------------------------------------------------------------------------
`ifndef LT_TILE_BOX_ADDRESS_WALKER_DEFINES_SVH
`define LT_TILE_BOX_ADDRESS_WALKER_DEFINES_SVH

// Same-cycle implication, masked while reset is held.
`define LTAW_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ltaw: same-cycle check failed");

// Next-cycle implication, masked while reset is held.
`define LTAW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ltaw: next-cycle check failed");

// Next-cycle implication that also covers reset itself.
`define LTAW_ASSERT_NEXT_RAW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("ltaw: reset check failed");

`endif

### hw/rtl/ltaw_pkg.sv
// ----------------------------------------------------------------------------
// ltaw_pkg
// Types, register indexes and pixel-format helpers for the tile box walker.
// ----------------------------------------------------------------------------
`default_nettype none

package ltaw_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIXEL_SIZE     = 3'd0,
        CFG_BOX_X          = 3'd1,
        CFG_BOX_Y          = 3'd2,
        CFG_BOX_WIDTH      = 3'd3,
        CFG_BOX_HEIGHT     = 3'd4,
        CFG_TILED_STRIDE   = 3'd5,
        CFG_LINEAR_STRIDE  = 3'd6,
        CFG_COPY_TO_LINEAR = 3'd7
    } t_cfg_idx;

    // Pixel size codes
    localparam logic [1:0] PIX_1B = 2'd0;
    localparam logic [1:0] PIX_2B = 2'd1;
    localparam logic [1:0] PIX_4B = 2'd2;
    localparam logic [1:0] PIX_8B = 2'd3;

    typedef struct packed {
        logic [1:0]  pixel_size_code;
        logic [10:0] box_x;
        logic [10:0] box_y;
        logic [11:0] box_width;
        logic [11:0] box_height;
        logic [15:0] tiled_row_stride;
        logic [15:0] linear_row_stride;
        logic        copy_to_linear;
    } t_cfg;

    typedef struct packed {
        logic copy_valid;
        logic last_line;
        logic to_linear;
    } t_line_flags;

    // Bytes in one microtile line: 8 for 1-byte pixels, 16 otherwise
    function automatic logic [4:0] line_bytes_of(input logic [1:0] code);
        return (code == PIX_1B) ? 5'd8 : 5'd16;
    endfunction

    // log2 of the line size
    function automatic logic [2:0] line_shift_of(input logic [1:0] code);
        return (code == PIX_1B) ? 3'd3 : 3'd4;
    endfunction

    // Tile height in lines: 64 / line bytes
    function automatic logic [3:0] tile_h_of(input logic [1:0] code);
        return (code == PIX_1B) ? 4'd8 : 4'd4;
    endfunction

    // Tile width in pixels: line bytes / pixel bytes
    function automatic logic [3:0] tile_w_of(input logic [1:0] code);
        logic [3:0] w;
        case (code)
            PIX_1B:  w = 4'd8;
            PIX_2B:  w = 4'd8;
            PIX_4B:  w = 4'd4;
            PIX_8B:  w = 4'd2;
            default: w = 4'd8;
        endcase
        return w;
    endfunction

    // log2 of 64 / tile width, the tiled byte step per pixel column
    function automatic logic [2:0] tile_shift_of(input logic [1:0] code);
        logic [2:0] s;
        case (code)
            PIX_1B:  s = 3'd3;
            PIX_2B:  s = 3'd3;
            PIX_4B:  s = 3'd4;
            PIX_8B:  s = 3'd5;
            default: s = 3'd3;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/ltaw_walker.sv
// ----------------------------------------------------------------------------
// ltaw_walker
// Walk position registers: rows of tiles, tiles of a row, lines of a tile.
// ----------------------------------------------------------------------------
`default_nettype none

module ltaw_walker #(
    parameter int MAX_DIM = 2048,
    localparam int PW = $clog2(MAX_DIM)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire ltaw_pkg::t_cfg        i_cfg,
    input  wire logic                  i_step,
    input  wire logic                  i_restart,
    output logic [PW-1:0]              o_row,
    output logic [PW-1:0]              o_col,
    output logic [2:0]                 o_line,
    output ltaw_pkg::t_line_flags      o_flags
);
    import ltaw_pkg::*;

    localparam int DW = PW + 1;
    localparam logic [31:0] MAX_DIM_W = 32'(MAX_DIM);

    logic [PW-1:0] r_row, r_col, n_row, n_col;
    logic [2:0]    r_line, n_line;
    logic          r_fin, n_fin;

    logic [PW-1:0] e_row, e_col;
    logic [2:0]    e_line;
    logic          e_fin;
    logic [DW-1:0] w_lim, h_lim;
    logic [3:0]    tile_w, tile_h;
    logic          end_tile, end_row, end_box, last;

    // Saturate the box to the largest supported size
    assign w_lim = ({20'd0, i_cfg.box_width} > MAX_DIM_W) ? DW'(MAX_DIM)
                                                        : DW'(i_cfg.box_width);
    assign h_lim = ({20'd0, i_cfg.box_height} > MAX_DIM_W) ? DW'(MAX_DIM)
                                                         : DW'(i_cfg.box_height);

    assign tile_w = tile_w_of(i_cfg.pixel_size_code);
    assign tile_h = tile_h_of(i_cfg.pixel_size_code);

    // Position this request works on, with a restart applied
    assign e_row  = i_restart ? '0 : r_row;
    assign e_col  = i_restart ? '0 : r_col;
    assign e_line = i_restart ? '0 : r_line;
    assign e_fin  = i_restart ? ((w_lim == '0) || (h_lim == '0)) : r_fin;

    assign end_tile = ({1'b0, e_line} + 4'd1) >= tile_h;
    assign end_row  = ({1'b0, e_col} + DW'(tile_w)) >= w_lim;
    assign end_box  = ({1'b0, e_row} + DW'(tile_h)) >= h_lim;
    assign last     = !e_fin && end_tile && end_row && end_box;

    always_comb begin
        n_row  = e_row;
        n_col  = e_col;
        n_line = e_line;
        n_fin  = e_fin;
        if (!e_fin) begin
            if (last) begin
                n_fin = 1'b1;
            end else if (!end_tile) begin
                n_line = e_line + 3'd1;
            end else begin
                n_line = '0;
                if (!end_row) begin
                    n_col = e_col + PW'(tile_w);
                end else begin
                    n_col = '0;
                    n_row = e_row + PW'(tile_h);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_line <= '0;
            r_fin  <= 1'b1;
        end else if (i_step) begin
            r_row  <= n_row;
            r_col  <= n_col;
            r_line <= n_line;
            r_fin  <= n_fin;
        end
    end

    assign o_row              = e_row;
    assign o_col              = e_col;
    assign o_line             = e_line;
    assign o_flags.copy_valid = !e_fin;
    assign o_flags.last_line  = last;
    assign o_flags.to_linear  = i_cfg.copy_to_linear;

endmodule

`default_nettype wire

### hw/rtl/ltaw_offset_calc.sv
// ----------------------------------------------------------------------------
// ltaw_offset_calc
// Tiled and linear byte offsets and copy size for one walk position.
// ----------------------------------------------------------------------------
`default_nettype none

module ltaw_offset_calc #(
    parameter int MAX_DIM = 2048,
    localparam int PW = $clog2(MAX_DIM)
) (
    input  wire ltaw_pkg::t_cfg        i_cfg,
    input  wire logic [PW-1:0]         i_row,
    input  wire logic [PW-1:0]         i_col,
    input  wire logic [2:0]            i_line,
    input  wire ltaw_pkg::t_line_flags i_flags,
    output logic [31:0]                o_tiled_offset,
    output logic [31:0]                o_linear_offset,
    output logic [4:0]                 o_line_bytes
);
    import ltaw_pkg::*;

    localparam int DW = PW + 1;
    localparam int YW = ((PW > 11) ? PW : 11) + 1;
    localparam int XW = YW + 5;
    localparam int CW = PW + 3;

    logic [YW-1:0]    y_sum, x_sum;
    logic [YW+15:0]   y_term;
    logic [XW-1:0]    x_term;
    logic [6:0]       line_term;
    logic [DW-1:0]    lin_row;
    logic [DW+15:0]   lin_term;
    logic [CW-1:0]    col_term;

    // Tiled: pixel row times stride, plus tile column bytes, plus line bytes
    assign y_sum     = YW'(i_cfg.box_y) + YW'(i_row);
    assign y_term    = (YW+16)'(y_sum) * (YW+16)'(i_cfg.tiled_row_stride);
    assign x_sum     = YW'(i_cfg.box_x) + YW'(i_col);
    assign x_term    = XW'(x_sum) << tile_shift_of(i_cfg.pixel_size_code);
    assign line_term = 7'(i_line) << line_shift_of(i_cfg.pixel_size_code);

    // Linear: pixel row times stride, plus column bytes
    assign lin_row  = {1'b0, i_row} + DW'(i_line);
    assign lin_term = (DW+16)'(lin_row) * (DW+16)'(i_cfg.linear_row_stride);
    assign col_term = CW'(i_col) << i_cfg.pixel_size_code;

    always_comb begin
        if (i_flags.copy_valid) begin
            o_tiled_offset  = 32'(y_term) + 32'(x_term) + 32'(line_term);
            o_linear_offset = 32'(lin_term) + 32'(col_term);
            o_line_bytes    = line_bytes_of(i_cfg.pixel_size_code);
        end else begin
            o_tiled_offset  = '0;
            o_linear_offset = '0;
            o_line_bytes    = '0;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/lt_tile_box_address_walker.sv
// ----------------------------------------------------------------------------
// lt_tile_box_address_walker
// Line-copy descriptor generator for moving a box between a linear image and
// an image stored as rows of 64-byte microtiles.
// ----------------------------------------------------------------------------
// Each accepted request yields one descriptor: the walk goes over rows of
// tiles, the tiles of a row left to right, then the lines of a tile, and a
// partial tile at the box edge is walked as a full tile. A request with
// restart set starts over at the box origin. The block takes one request
// every clock cycle unless the output stalls: the walk counters step in the
// cycle the request is accepted, the position is held in a stage register,
// and the offset multipliers (two 16-bit stride products in parallel) feed
// the result register, so a descriptor passes through those two register
// stages. A stalled result holds in the result register while one more
// request can still enter the stage register. Empty or finished walks
// return a descriptor with copy_valid low and zero offsets. Offsets wrap
// modulo 2^32. Write configuration only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module lt_tile_box_address_walker #(
    parameter int MAX_DIM = 2048
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration write port
    input  wire logic                           i_cfg_we,
    input  wire logic [ltaw_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [ltaw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // request channel
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_restart,
    // descriptor channel
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [31:0]                         o_tiled_offset,
    output logic [31:0]                         o_linear_offset,
    output logic [4:0]                          o_line_bytes,
    output logic                                o_to_linear,
    output logic                                o_copy_valid,
    output logic                                o_last_line
);
    import ltaw_pkg::*;

    localparam int PW = $clog2(MAX_DIM);

    // Register values after reset: 4-byte pixels, empty box, tiled to linear
    localparam t_cfg CFG_RESET = '{
        pixel_size_code:   PIX_4B,
        box_x:             '0,
        box_y:             '0,
        box_width:         '0,
        box_height:        '0,
        tiled_row_stride:  '0,
        linear_row_stride: '0,
        copy_to_linear:    1'b1
    };

    // Configuration registers
    t_cfg r_cfg;

    // Handshake
    logic out_free;
    logic s1_move;
    logic in_acc;

    // Walker output for the request being accepted
    logic [PW-1:0] walk_row, walk_col;
    logic [2:0]    walk_line;
    t_line_flags   walk_flags;

    // Stage register: position of the request in flight
    logic          r_s1_valid;
    logic [PW-1:0] r_s1_row, r_s1_col;
    logic [2:0]    r_s1_line;
    t_line_flags   r_s1_flags;

    // Offsets computed from the stage register
    logic [31:0] n_tiled, n_linear;
    logic [4:0]  n_bytes;

    // Result register
    logic r_out_valid;

    // ------------------------------------------------------------------
    // Configuration writes; a write takes effect at the next edge
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PIXEL_SIZE:     r_cfg.pixel_size_code   <= i_cfg_data[1:0];
                CFG_BOX_X:          r_cfg.box_x             <= i_cfg_data[10:0];
                CFG_BOX_Y:          r_cfg.box_y             <= i_cfg_data[10:0];
                CFG_BOX_WIDTH:      r_cfg.box_width         <= i_cfg_data[11:0];
                CFG_BOX_HEIGHT:     r_cfg.box_height        <= i_cfg_data[11:0];
                CFG_TILED_STRIDE:   r_cfg.tiled_row_stride  <= i_cfg_data;
                CFG_LINEAR_STRIDE:  r_cfg.linear_row_stride <= i_cfg_data;
                CFG_COPY_TO_LINEAR: r_cfg.copy_to_linear    <= i_cfg_data[0];
                default:            r_cfg                   <= r_cfg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: the result register drains when free or taken; the
    // stage register moves on when the result register can take it.
    // ------------------------------------------------------------------
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_move    = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    // ------------------------------------------------------------------
    // Walk counters: advance once per accepted request
    // ------------------------------------------------------------------
    ltaw_walker #(
        .MAX_DIM (MAX_DIM)
    ) u_walker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_step    (in_acc),
        .i_restart (i_restart),
        .o_row     (walk_row),
        .o_col     (walk_col),
        .o_line    (walk_line),
        .o_flags   (walk_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Capture the position of the accepted request
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_row   <= walk_row;
            r_s1_col   <= walk_col;
            r_s1_line  <= walk_line;
            r_s1_flags <= walk_flags;
        end
    end

    // ------------------------------------------------------------------
    // Offset arithmetic between the stage and result registers
    // ------------------------------------------------------------------
    ltaw_offset_calc #(
        .MAX_DIM (MAX_DIM)
    ) u_offset_calc (
        .i_cfg           (r_cfg),
        .i_row           (r_s1_row),
        .i_col           (r_s1_col),
        .i_line          (r_s1_line),
        .i_flags         (r_s1_flags),
        .o_tiled_offset  (n_tiled),
        .o_linear_offset (n_linear),
        .o_line_bytes    (n_bytes)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    // Load the descriptor; hold it while the consumer stalls
    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            o_tiled_offset  <= n_tiled;
            o_linear_offset <= n_linear;
            o_line_bytes    <= n_bytes;
            o_to_linear     <= r_s1_flags.to_linear;
            o_copy_valid    <= r_s1_flags.copy_valid;
            o_last_line     <= r_s1_flags.last_line;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

### hw/rtl/ltaw_chk.sv
// ----------------------------------------------------------------------------
// ltaw_chk
// Port-level checks for the tile box address walker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lt_tile_box_address_walker_defines.svh"

module ltaw_chk (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        o_in_stall,
    input  wire logic        o_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [31:0] o_tiled_offset,
    input  wire logic [31:0] o_linear_offset,
    input  wire logic [4:0]  o_line_bytes,
    input  wire logic        o_copy_valid,
    input  wire logic        o_last_line
);

    // Hold a stalled descriptor
    `LTAW_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_tiled_offset) && $stable(o_linear_offset) && $stable(o_line_bytes) && $stable(o_last_line) && $stable(o_copy_valid))

    // The final line is always a real copy
    `LTAW_ASSERT_IMP(a_last_is_copy, o_out_valid && o_last_line, o_copy_valid)

    // A real copy moves one microtile line
    `LTAW_ASSERT_IMP(a_line_size, o_out_valid && o_copy_valid, o_line_bytes == 5'd8 || o_line_bytes == 5'd16)

    // Reset empties the pipeline
    `LTAW_ASSERT_NEXT_RAW(a_reset_empty, !i_rst_n, !o_out_valid && !o_in_stall)

endmodule

bind lt_tile_box_address_walker ltaw_chk u_ltaw_chk (.*);

`default_nettype wire

### dv/lt_tile_box_walk_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tile box walk checker
// Watches the configuration port and both channels of the tile box address
// walker, predicts each line-copy descriptor and compares it field by field.
// ----------------------------------------------------------------------------
module lt_tile_box_walk_checker #(
    parameter int MAX_DIM = 2048
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ltaw_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ltaw_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic                              i_restart,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic [31:0]                       i_tiled_offset,
    input  logic [31:0]                       i_linear_offset,
    input  logic [4:0]                        i_line_bytes,
    input  logic                              i_to_linear,
    input  logic                              i_copy_valid,
    input  logic                              i_last_line,
    output int                                o_fail_count,
    output int                                o_pending,
    output int                                o_checked,
    output int                                o_last_lines
);
    import ltaw_pkg::*;

    typedef struct packed {
        logic [31:0] tiled_offset;
        logic [31:0] linear_offset;
        logic [4:0]  line_bytes;
        logic        to_linear;
        logic        copy_valid;
        logic        last_line;
    } t_line_copy;

    // shadow registers
    logic [31:0] sz_code, org_x, org_y, span_w, span_h, tstride, lstride, dir_to_linear;
    // walk position
    logic [31:0] tile_row, tile_col, tile_line;
    logic        walk_done;

    t_line_copy line_copies[$];
    int mismatches = 0;
    int backlog    = 0;
    int checked    = 0;
    int last_lines = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = backlog;
    assign o_checked    = checked;
    assign o_last_lines = last_lines;

    // Advance the walk by one request and return the descriptor it yields.
    function automatic t_line_copy next_line_copy(input logic rs);
        t_line_copy  d;
        logic [31:0] pix_bytes, lbytes, tile_w, tile_h, w, h;
        logic        end_tile, end_row, end_box;
        pix_bytes = 32'd1 << sz_code[1:0];
        lbytes    = (sz_code[1:0] == PIX_1B) ? 32'd8 : 32'd16;
        tile_w    = lbytes / pix_bytes;
        tile_h    = 32'd64 / lbytes;
        w         = (span_w > MAX_DIM) ? MAX_DIM : span_w;
        h         = (span_h > MAX_DIM) ? MAX_DIM : span_h;
        d           = '0;
        d.to_linear = dir_to_linear[0];
        if (rs) begin
            tile_row  = 0;
            tile_col  = 0;
            tile_line = 0;
            walk_done = (w == 0) || (h == 0);
        end
        if (walk_done)
            return d;
        d.tiled_offset  = (org_y + tile_row) * tstride
                        + (org_x + tile_col) * (32'd64 / tile_w)
                        + tile_line * lbytes;
        d.linear_offset = (tile_row + tile_line) * lstride + tile_col * pix_bytes;
        d.line_bytes    = lbytes[4:0];
        d.copy_valid    = 1'b1;
        // a position already past a shrunken bound still ends its level
        end_tile = (tile_line + 1 >= tile_h);
        end_row  = (tile_col + tile_w >= w);
        end_box  = (tile_row + tile_h >= h);
        if (end_tile && end_row && end_box) begin
            d.last_line = 1'b1;
            walk_done   = 1'b1;
            return d;
        end
        if (!end_tile) begin
            tile_line = (tile_line + 1) & 32'd7;
        end else begin
            tile_line = 0;
            if (!end_row) begin
                tile_col = tile_col + tile_w;
            end else begin
                tile_col = 0;
                tile_row = tile_row + tile_h;
            end
        end
        return d;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_line_copy want;
        if (!i_rst_n) begin
            sz_code       = 32'(PIX_4B);
            org_x         = 0;
            org_y         = 0;
            span_w        = 0;
            span_h        = 0;
            tstride       = 0;
            lstride       = 0;
            dir_to_linear = 1;
            tile_row      = 0;
            tile_col      = 0;
            tile_line     = 0;
            walk_done     = 1'b1;
            line_copies.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PIXEL_SIZE:     sz_code       = 32'(i_cfg_data[1:0]);
                    CFG_BOX_X:          org_x         = 32'(i_cfg_data[10:0]);
                    CFG_BOX_Y:          org_y         = 32'(i_cfg_data[10:0]);
                    CFG_BOX_WIDTH:      span_w        = 32'(i_cfg_data[11:0]);
                    CFG_BOX_HEIGHT:     span_h        = 32'(i_cfg_data[11:0]);
                    CFG_TILED_STRIDE:   tstride       = 32'(i_cfg_data[15:0]);
                    CFG_LINEAR_STRIDE:  lstride       = 32'(i_cfg_data[15:0]);
                    CFG_COPY_TO_LINEAR: dir_to_linear = 32'(i_cfg_data[0]);
                    default: ;
                endcase
            end
            // push before pop so a fast descriptor never finds the queue empty
            if (i_in_valid && !i_in_stall)
                line_copies.push_back(next_line_copy(i_restart));
            if (i_out_valid && !i_out_stall) begin
                if (line_copies.size() == 0) begin
                    $error("descriptor accepted with no request outstanding");
                    mismatches++;
                end else begin
                    want = line_copies.pop_front();
                    check_field("tiled_offset", want.tiled_offset, i_tiled_offset);
                    check_field("linear_offset", want.linear_offset, i_linear_offset);
                    check_field("line_bytes", 32'(want.line_bytes), 32'(i_line_bytes));
                    check_field("to_linear", 32'(want.to_linear), 32'(i_to_linear));
                    check_field("copy_valid", 32'(want.copy_valid), 32'(i_copy_valid));
                    check_field("last_line", 32'(want.last_line), 32'(i_last_line));
                    checked++;
                    if (want.last_line)
                        last_lines++;
                end
            end
        end
        backlog <= line_copies.size();
    end

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tile box address walker testbench
// Programs box settings, drives walk requests in bursts against a stalling
// descriptor sink, and takes its verdict from the walk checker.
// ----------------------------------------------------------------------------
module testbench;
    import ltaw_pkg::*;

    localparam int MAX_DIM = 2048;

    typedef enum int {
        STALL_NONE,
        STALL_SPARSE,
        STALL_RUNS,
        STALL_HEAVY
    } t_stall_mode;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_we;
    t_cfg_idx                cfg_idx;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic                    restart;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [31:0]             tiled_offset;
    logic [31:0]             linear_offset;
    logic [4:0]              line_bytes;
    logic                    to_linear;
    logic                    copy_valid;
    logic                    last_line;

    int fail_count;
    int pending;
    int checked;
    int last_lines;

    int items_sent = 0;
    int phases     = 0;
    int burst_left = 0;

    // 50 MHz
    always #10 clk = ~clk;

    lt_tile_box_address_walker #(
        .MAX_DIM(MAX_DIM)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_restart      (restart),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_tiled_offset (tiled_offset),
        .o_linear_offset(linear_offset),
        .o_line_bytes   (line_bytes),
        .o_to_linear    (to_linear),
        .o_copy_valid   (copy_valid),
        .o_last_line    (last_line)
    );

    lt_tile_box_walk_checker #(
        .MAX_DIM(MAX_DIM)
    ) walk_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_restart      (restart),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_tiled_offset (tiled_offset),
        .i_linear_offset(linear_offset),
        .i_line_bytes   (line_bytes),
        .i_to_linear    (to_linear),
        .i_copy_valid   (copy_valid),
        .i_last_line    (last_line),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_last_lines   (last_lines)
    );

    // ------------------------------------------------------------------------
    // Descriptor sink: switch between stall styles at random so back-pressure
    // lands on every stage of the pipeline, with clean stretches in between.
    // ------------------------------------------------------------------------
    t_stall_mode stall_mode  = STALL_NONE;
    int          mode_left   = 0;
    int          run_left    = 0;
    logic        run_stalled = 1'b0;

    always @(negedge clk) begin : sink_pattern
        logic next_stall;
        if (mode_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 150);
        end
        mode_left--;
        case (stall_mode)
            STALL_NONE:   next_stall = 1'b0;
            STALL_SPARSE: next_stall = ($urandom_range(0, 3) == 0);
            STALL_RUNS: begin
                // alternate long stalls with short open windows
                if (run_left == 0) begin
                    run_stalled = !run_stalled;
                    run_left    = run_stalled ? $urandom_range(1, 12) : $urandom_range(1, 6);
                end
                run_left--;
                next_stall = run_stalled;
            end
            default:      next_stall = ($urandom_range(0, 3) != 0);
        endcase
        out_stall <= next_stall;
    end

    // ------------------------------------------------------------------------
    // Request driver: requests go out in bursts of random length, separated by
    // random gaps (sometimes none). Valid stays high across back-to-back
    // requests; only restart changes.
    // ------------------------------------------------------------------------
    task automatic send_req(input logic rs);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        restart  <= rs;
        // hold until the walker takes the request
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    // Drop valid and wait for every outstanding descriptor, then let the
    // two-stage pipeline drain before anything touches the registers.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write one register from a box setting; the unused upper data bits get
    // junk half the time, which the walker must ignore.
    task automatic cfg_reg(input t_cfg_idx idx, input t_cfg c);
        logic [CFG_DATA_W-1:0] value, mask, noise;
        case (idx)
            CFG_PIXEL_SIZE:     begin value = 16'(c.pixel_size_code);   mask = 16'h0003; end
            CFG_BOX_X:          begin value = 16'(c.box_x);             mask = 16'h07FF; end
            CFG_BOX_Y:          begin value = 16'(c.box_y);             mask = 16'h07FF; end
            CFG_BOX_WIDTH:      begin value = 16'(c.box_width);         mask = 16'h0FFF; end
            CFG_BOX_HEIGHT:     begin value = 16'(c.box_height);        mask = 16'h0FFF; end
            CFG_TILED_STRIDE:   begin value = c.tiled_row_stride;       mask = 16'hFFFF; end
            CFG_LINEAR_STRIDE:  begin value = c.linear_row_stride;      mask = 16'hFFFF; end
            default:            begin value = 16'(c.copy_to_linear);    mask = 16'h0001; end
        endcase
        noise = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'($urandom);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value | (noise & ~mask);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic program_box(input t_cfg c);
        for (int r = CFG_PIXEL_SIZE; r <= CFG_COPY_TO_LINEAR; r++)
            cfg_reg(t_cfg_idx'(r), c);
    endtask

    function automatic t_cfg make_box(input logic [1:0] pix, input logic [10:0] x,
                                      input logic [10:0] y, input logic [11:0] w,
                                      input logic [11:0] h, input logic [15:0] ts,
                                      input logic [15:0] ls, input logic dir);
        t_cfg c;
        c.pixel_size_code   = pix;
        c.box_x             = x;
        c.box_y             = y;
        c.box_width         = w;
        c.box_height        = h;
        c.tiled_row_stride  = ts;
        c.linear_row_stride = ls;
        c.copy_to_linear    = dir;
        return c;
    endfunction

    // Mostly small boxes so walks finish; a few empty, full-size or oversized.
    function automatic logic [11:0] pick_dim();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 2)
            return 12'd0;
        else if (sel < 14)
            return 12'($urandom_range(1, 24));
        else if (sel < 17)
            return 12'($urandom_range(25, 96));
        else if (sel < 18)
            return 12'd2048;
        else
            return 12'($urandom_range(2049, 4095));
    endfunction

    function automatic logic [15:0] pick_stride();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 16'd0;
        else if (sel == 1)
            return 16'hFFFF;
        else
            return 16'($urandom);
    endfunction

    function automatic t_cfg random_box();
        logic [10:0] x, y;
        x = 11'($urandom);
        y = 11'($urandom);
        // keep most origins tile aligned
        if ($urandom_range(0, 3) != 0) begin
            x[2:0] = 3'd0;
            y[2:0] = 3'd0;
        end
        return make_box(2'($urandom_range(0, 3)), x, y, pick_dim(), pick_dim(),
                        pick_stride(), pick_stride(), 1'($urandom_range(0, 1)));
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_cfg box;
        int   item_goal;
        int   pix_b, lb, tw, th, w, h, walk_len;

        rst_n    = 1'b0;
        cfg_we   = 1'b0;
        cfg_idx  = CFG_PIXEL_SIZE;
        cfg_data = '0;
        in_valid = 1'b0;
        restart  = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // After reset no walk is active, and the reset box is empty.
        send_req(1'b0);
        send_req(1'b1);

        // One aligned 1-byte tile: eight lines, the last flagged, then a
        // finished walk.
        settle();
        phases++;
        program_box(make_box(PIX_1B, 11'd8, 11'd8, 12'd8, 12'd8, 16'd64, 16'd8, 1'b1));
        send_req(1'b1);
        repeat (8) send_req(1'b0);

        // Extremes: 8-byte pixels, unaligned far origin, oversized box,
        // widest strides, linear-to-tiled direction.
        settle();
        phases++;
        program_box(make_box(PIX_8B, 11'd2047, 11'd2047, 12'd4095, 12'd4095,
                             16'hFFFF, 16'hFFFF, 1'b0));
        send_req(1'b1);
        repeat (3) send_req(1'b0);

        // Shrink the box under the walk in progress and carry on without
        // restarting.
        settle();
        phases++;
        program_box(make_box(PIX_1B, 11'd2047, 11'd2047, 12'd2, 12'd2,
                             16'hFFFF, 16'hFFFF, 1'b0));
        repeat (3) send_req(1'b0);

        // 2-byte pixels with zero strides.
        settle();
        phases++;
        program_box(make_box(PIX_2B, 11'd0, 11'd0, 12'd16, 12'd4, 16'd0, 16'd0, 1'b1));
        send_req(1'b1);
        repeat (2) send_req(1'b0);

        // Random phases: mostly full walks of random boxes, with stray
        // restarts, some pure noise, and some register nudges mid-walk.
        item_goal = items_sent + 650;
        while (items_sent < item_goal) begin
            settle();
            phases++;
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 2))
                    cfg_reg(t_cfg_idx'($urandom_range(0, 7)), random_box());
                repeat ($urandom_range(4, 30)) send_req($urandom_range(0, 29) == 0);
            end else begin
                box = random_box();
                program_box(box);
                if ($urandom_range(0, 5) == 0) begin
                    repeat ($urandom_range(3, 25)) send_req($urandom_range(0, 2) == 0);
                end else begin
                    // lines in a full walk, up to a request or two past its end, capped at 120
                    pix_b    = 1 << box.pixel_size_code;
                    lb       = (box.pixel_size_code == PIX_1B) ? 8 : 16;
                    tw       = lb / pix_b;
                    th       = 64 / lb;
                    w        = (box.box_width > MAX_DIM) ? MAX_DIM : box.box_width;
                    h        = (box.box_height > MAX_DIM) ? MAX_DIM : box.box_height;
                    walk_len = ((w + tw - 1) / tw) * ((h + th - 1) / th) * th;
                    walk_len = walk_len - 1 + $urandom_range(0, 2);
                    if (walk_len > 120)
                        walk_len = 120;
                    send_req(1'b1);
                    repeat (walk_len) send_req($urandom_range(0, 39) == 0);
                end
            end
        end

        settle();
        $display("Sent %0d walk requests over %0d configuration phases.", items_sent, phases);
        $display("Checked %0d descriptors; %0d box walks reached their last line.",
                 checked, last_lines);
        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #4_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule
